>>> src/mpm_pkg.sv
package mpm_pkg;

    localparam int NUM_PARTICLES = 32;
    localparam int ADDR_W        = $clog2(NUM_PARTICLES);
    localparam int IDX_W         = 5;
    localparam int POS_W         = 16;
    localparam int DRAW_W        = 16;
    localparam int CFG_W         = 16;
    localparam int CFG_ADDR_W    = 3;
    localparam int COUNT_W       = 32;
    localparam int PROB_W        = 17;
    localparam int IN_DATA_W     = 88;
    localparam int OUT_DATA_W    = 72;

    // log2(e) in Q.16, used to turn a natural exponent into a power of two.
    localparam logic [16:0] LOG2E_Q16  = 17'd94548;
    // Beyond this power of two the probability is taken as zero.
    localparam logic [8:0]  SHIFT_LIMIT = 9'd16;

    localparam logic [CFG_W-1:0] BOX_WIDTH_RST  = 16'd40960;
    localparam logic [CFG_W-1:0] BOX_HEIGHT_RST = 16'd40960;
    localparam logic [CFG_W-1:0] MAX_STEP_X_RST = 16'd4096;
    localparam logic [CFG_W-1:0] MAX_STEP_Y_RST = 16'd4096;
    localparam logic [CFG_W-1:0] GRAVITY_RST    = 16'd4022;

    typedef enum logic [CFG_ADDR_W-1:0] {
        CFG_BOX_WIDTH  = 3'd0,
        CFG_BOX_HEIGHT = 3'd1,
        CFG_MAX_STEP_X = 3'd2,
        CFG_MAX_STEP_Y = 3'd3,
        CFG_GRAVITY    = 3'd4
    } t_cfg_reg;

    typedef enum logic {
        CMD_LOAD  = 1'b0,
        CMD_TRIAL = 1'b1
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_READ,
        S_PROP,
        S_START,
        S_WAIT,
        S_OUT
    } t_state;

    // 2^(-j/16) in Q1.16 for j = 0 .. 16.
    function automatic logic [PROB_W-1:0] pow2_neg(input logic [4:0] j);
        logic [PROB_W-1:0] v;
        case (j)
            5'd0:    v = 17'd65536;
            5'd1:    v = 17'd62757;
            5'd2:    v = 17'd60097;
            5'd3:    v = 17'd57549;
            5'd4:    v = 17'd55109;
            5'd5:    v = 17'd52773;
            5'd6:    v = 17'd50535;
            5'd7:    v = 17'd48393;
            5'd8:    v = 17'd46341;
            5'd9:    v = 17'd44376;
            5'd10:   v = 17'd42495;
            5'd11:   v = 17'd40693;
            5'd12:   v = 17'd38968;
            5'd13:   v = 17'd37316;
            5'd14:   v = 17'd35734;
            5'd15:   v = 17'd34219;
            5'd16:   v = 17'd32768;
            default: v = 17'd0;
        endcase
        return v;
    endfunction

endpackage

>>> src/mpm_prob.sv
module mpm_prob
    import mpm_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [CFG_W-1:0]  i_gravity,
    input  logic [POS_W-1:0]  i_dy,
    output logic              o_valid,
    output logic [PROB_W-1:0] o_prob
);

    // Four stages: energy, base-2 exponent, table interpolation, shift.
    logic [3:0]        r_vld;
    logic [23:0]       r_e;
    logic [24:0]       r_t;
    logic [PROB_W-1:0] r_tj;
    logic [23:0]       r_prod;
    logic [8:0]        r_n;
    logic [PROB_W-1:0] r_prob;

    logic [31:0]       w_p1;
    logic [40:0]       w_p2;
    logic [4:0]        w_j;
    logic [PROB_W-1:0] w_tj;
    logic [PROB_W-1:0] w_tj1;
    logic [11:0]       w_diff;
    logic [PROB_W-1:0] w_v;

    always_comb begin
        w_p1   = 32'(i_gravity) * 32'(i_dy);
        w_p2   = 41'(r_e) * 41'(LOG2E_Q16);
        w_j    = {1'b0, r_t[15:12]};
        w_tj   = pow2_neg(w_j);
        w_tj1  = pow2_neg(w_j + 5'd1);
        w_diff = 12'(w_tj - w_tj1);
        w_v    = r_tj - PROB_W'(r_prod[23:12]);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            r_vld <= {r_vld[2:0], i_valid};
        end
    end

    always_ff @(posedge i_clk) begin
        r_e    <= w_p1[31:8];
        r_t    <= w_p2[40:16];
        r_tj   <= w_tj;
        r_prod <= 24'(w_diff) * 24'(r_t[11:0]);
        r_n    <= r_t[24:16];
        if (r_n > SHIFT_LIMIT) begin
            r_prob <= '0;
        end else begin
            r_prob <= w_v >> r_n[4:0];
        end
    end

    assign o_valid = r_vld[3];
    assign o_prob  = r_prob;

endmodule

>>> src/metropolis_particle_move.sv
// Channel      | Direction | Handshake                     | Content
// s_axis       | in        | s_axis_tvalid / s_axis_tready | load or trial item
// m_axis       | out       | m_axis_tvalid / m_axis_tready | one result per item
// cfg          | in        | i_cfg_valid / o_cfg_ready     | register index and data
//
// A load item goes straight to the output; a trial item passes through one position
// memory read, the displacement multiply, the box check, and the four-stage
// acceptance probability unit before the write-back.
// One item is worked on at a time; the output register lets the next item
// enter while a result waits for m_axis_tready. Reset clears the count and
// restores the register defaults; positions are undefined until loaded.
module metropolis_particle_move
    import mpm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // [4:0] particle_index, [20:5] load_x, [36:21] load_y,
    // [52:37] step_draw_x, [68:53] step_draw_y, [84:69] accept_draw
    input  logic [IN_DATA_W-1:0]  s_axis_tdata,
    // [0] cmd
    input  logic [0:0]            s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // [0] accepted, [1] left_box, [6:2] moved_index, [22:7] new_x,
    // [38:23] new_y, [70:39] accept_total
    output logic [OUT_DATA_W-1:0] m_axis_tdata,
    input  logic                  i_cfg_valid,
    output logic                  o_cfg_ready,
    input  logic [CFG_ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]      i_cfg_data
);

    t_state r_state, n_state;

    logic [CFG_W-1:0] r_box_w, r_box_h, r_step_x, r_step_y, r_gravity;

    logic [31:0]       r_pos_mem [NUM_PARTICLES];
    logic [31:0]       r_rdata;

    logic [IDX_W-1:0]  r_idx;
    logic              r_ok;
    logic [DRAW_W-1:0] r_sx, r_sy, r_ad;
    logic signed [17:0] r_dx, r_dy;
    logic [POS_W-1:0]  r_ox, r_oy;
    logic [POS_W-1:0]  r_kx, r_ky;
    logic [POS_W-1:0]  r_dyp;
    logic              r_left;
    logic [COUNT_W-1:0] r_count;

    logic              r_res_acc, r_res_left;
    logic [POS_W-1:0]  r_res_x, r_res_y;

    logic                  r_m_valid;
    logic [OUT_DATA_W-1:0] r_m_data;

    logic               w_in_acc;
    logic [IDX_W-1:0]   w_in_idx;
    logic [POS_W-1:0]   w_in_lx, w_in_ly;
    logic               w_in_range;
    logic               w_out_free;
    logic signed [17:0] w_ux, w_uy;
    logic signed [34:0] w_mx, w_my;
    logic signed [18:0] w_px, w_py;
    logic               w_left;
    logic [POS_W-1:0]   w_kx, w_ky;
    logic               w_prob_start;
    logic               w_prob_valid;
    logic [PROB_W-1:0]  w_prob;
    logic               w_accept;
    logic               w_mem_we;
    logic [ADDR_W-1:0]  w_mem_wa;
    logic [31:0]        w_mem_wd;

    assign o_cfg_ready = 1'b1;

    assign w_in_idx   = s_axis_tdata[4:0];
    assign w_in_lx    = s_axis_tdata[20:5];
    assign w_in_ly    = s_axis_tdata[36:21];
    assign w_in_acc   = s_axis_tvalid && s_axis_tready;
    assign w_in_range = 32'(w_in_idx) < NUM_PARTICLES;
    assign w_out_free = !r_m_valid || m_axis_tready;

    // Displacement is floor((2u - 1.0) * step), taken from the product's upper bits.
    always_comb begin
        w_ux = $signed({1'b0, r_sx, 1'b0}) - 18'sd65536;
        w_uy = $signed({1'b0, r_sy, 1'b0}) - 18'sd65536;
        w_mx = 35'(w_ux) * 35'($signed({1'b0, r_step_x}));
        w_my = 35'(w_uy) * 35'($signed({1'b0, r_step_y}));
        w_px = $signed({3'b000, r_ox}) + 19'(r_dx);
        w_py = $signed({3'b000, r_oy}) + 19'(r_dy);
        w_left = w_px[18] || (w_px[17:0] > {2'b00, r_box_w})
              || w_py[18] || (w_py[17:0] > {2'b00, r_box_h});
        w_kx = w_left ? r_ox : w_px[15:0];
        w_ky = w_left ? r_oy : w_py[15:0];
    end

    assign w_accept = w_prob >= {1'b0, r_ad};

    mpm_prob u_prob (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_valid   (w_prob_start),
        .i_gravity (r_gravity),
        .i_dy      (r_dyp),
        .o_valid   (w_prob_valid),
        .o_prob    (w_prob)
    );

    always_comb begin
        n_state       = r_state;
        s_axis_tready = 1'b0;
        w_prob_start  = 1'b0;
        w_mem_we      = 1'b0;
        w_mem_wa      = ADDR_W'(r_idx);
        w_mem_wd      = {r_ky, r_kx};
        case (r_state)
            S_IDLE: begin
                s_axis_tready = 1'b1;
                if (s_axis_tvalid) begin
                    if (s_axis_tuser[0] == CMD_LOAD || !w_in_range) begin
                        n_state = S_OUT;
                    end else begin
                        n_state = S_READ;
                    end
                    if (s_axis_tuser[0] == CMD_LOAD && w_in_range) begin
                        w_mem_we = 1'b1;
                        w_mem_wa = ADDR_W'(w_in_idx);
                        w_mem_wd = {w_in_ly, w_in_lx};
                    end
                end
            end
            S_READ:  n_state = S_PROP;
            S_PROP:  n_state = S_START;
            S_START: begin
                w_prob_start = 1'b1;
                n_state      = S_WAIT;
            end
            S_WAIT: begin
                if (w_prob_valid) begin
                    w_mem_we = w_accept;
                    n_state  = S_OUT;
                end
            end
            S_OUT: begin
                if (w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_mem_we) begin
            r_pos_mem[w_mem_wa] <= w_mem_wd;
        end
        if (w_in_acc) begin
            r_rdata <= r_pos_mem[ADDR_W'(w_in_idx)];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_box_w   <= BOX_WIDTH_RST;
            r_box_h   <= BOX_HEIGHT_RST;
            r_step_x  <= MAX_STEP_X_RST;
            r_step_y  <= MAX_STEP_Y_RST;
            r_gravity <= GRAVITY_RST;
        end else if (i_cfg_valid) begin
            case (i_cfg_addr)
                CFG_BOX_WIDTH:  r_box_w   <= i_cfg_data;
                CFG_BOX_HEIGHT: r_box_h   <= i_cfg_data;
                CFG_MAX_STEP_X: r_step_x  <= i_cfg_data;
                CFG_MAX_STEP_Y: r_step_y  <= i_cfg_data;
                CFG_GRAVITY:    r_gravity <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Item datapath.
    always_ff @(posedge i_clk) begin
        if (r_state == S_IDLE && w_in_acc) begin
            r_idx      <= w_in_idx;
            r_ok       <= w_in_range;
            r_sx       <= s_axis_tdata[52:37];
            r_sy       <= s_axis_tdata[68:53];
            r_ad       <= s_axis_tdata[84:69];
            r_res_acc  <= 1'b0;
            r_res_left <= 1'b0;
            r_res_x    <= (s_axis_tuser[0] == CMD_LOAD && w_in_range) ? w_in_lx : '0;
            r_res_y    <= (s_axis_tuser[0] == CMD_LOAD && w_in_range) ? w_in_ly : '0;
        end
        if (r_state == S_READ) begin
            r_ox <= r_rdata[15:0];
            r_oy <= r_rdata[31:16];
            r_dx <= w_mx[33:16];
            r_dy <= w_my[33:16];
        end
        if (r_state == S_PROP) begin
            r_kx   <= w_kx;
            r_ky   <= w_ky;
            r_left <= w_left;
            r_dyp  <= (w_ky > r_oy) ? (w_ky - r_oy) : '0;
        end
        if (r_state == S_WAIT && w_prob_valid) begin
            r_res_acc  <= w_accept;
            r_res_left <= r_left;
            r_res_x    <= w_accept ? r_kx : r_ox;
            r_res_y    <= w_accept ? r_ky : r_oy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count <= '0;
        end else if (r_state == S_WAIT && w_prob_valid && w_accept) begin
            r_count <= r_count + COUNT_W'(1);
        end
    end

    // Output register: frees the item path while a result waits downstream.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (r_state == S_OUT && w_out_free) begin
            r_m_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_m_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_OUT && w_out_free) begin
            r_m_data <= {1'b0, r_count, r_res_y, r_res_x, r_idx,
                         r_res_left && r_ok, r_res_acc && r_ok};
        end
    end

    assign m_axis_tvalid = r_m_valid;
    assign m_axis_tdata  = r_m_data;

endmodule
